// File: src/sliding_window_min_max_defines.svh
// Assertion macros for the sliding window min/max RTL.
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a consequence holds in the same cycle as its cause.
`define SWMM_ASSERT_SAME(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("swmm: same-cycle check failed");

// Check that a consequence holds in the cycle after its cause.
`define SWMM_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("swmm: next-cycle check failed");

`else

`define SWMM_ASSERT_SAME(label, cause, effect)
`define SWMM_ASSERT_NEXT(label, cause, effect)

`endif

`endif

// File: src/swmm_pkg.sv
// Types and constants of the sliding window min/max block.
package swmm_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int WSIZE_W     = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    typedef logic signed [SAMPLE_W-1:0] swmm_sample_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_SIZE = 1'b0,
        REG_SELECT_MAX  = 1'b1
    } swmm_reg_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } swmm_state_t;

    typedef struct packed {
        logic [WSIZE_W-1:0] window_size;
        logic               select_max;
    } swmm_cfg_t;

    typedef struct packed {
        logic         valid;
        swmm_sample_t extreme;
    } swmm_result_t;

endpackage

// File: src/swmm_if.sv
// Valid/ready channels for samples and results.
interface swmm_in_if;
    logic                  valid;
    logic                  ready;
    swmm_pkg::swmm_sample_t sample;
    logic                  new_sequence;

    modport source (output valid, output sample, output new_sequence, input ready);
    modport sink   (input valid, input sample, input new_sequence, output ready);
endinterface

interface swmm_out_if;
    logic                  valid;
    logic                  ready;
    swmm_pkg::swmm_sample_t extreme;

    modport source (output valid, output extreme, input ready);
    modport sink   (input valid, input extreme, output ready);
endinterface

// File: src/swmm_mem.sv
// Deque storage: one write port, two registered read ports.
module swmm_mem #(
    parameter int  DEPTH  = 1024,
    parameter int  WIDTH  = 43,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Write one entry, read two
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: src/swmm_seq.sv
// Deque steps: front expiry, back pruning, append (may stall); one per cycle.
`include "sliding_window_min_max_defines.svh"

module swmm_seq #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    swmm_in_if.sink                 samples,
    input  swmm_pkg::swmm_cfg_t     cfg,
    input  logic                    out_free,
    output swmm_pkg::swmm_result_t  result
);

    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int ENTRY_W = swmm_pkg::SAMPLE_W + CNT_W;

    swmm_pkg::swmm_state_t  state_reg, state_next;
    logic [PTR_W-1:0]       front_reg, front_next;
    logic [PTR_W-1:0]       back_reg, back_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       seen_reg, seen_next;
    swmm_pkg::swmm_sample_t sample_reg, sample_next;

    logic [PTR_W-1:0]       rd_addr_back;
    logic [ENTRY_W-1:0]     front_entry;
    logic [ENTRY_W-1:0]     back_entry;
    logic                   wr_en;

    logic [31:0]            ws_wide;
    logic [CNT_W-1:0]       win_len;
    logic [CNT_W-1:0]       front_pos;
    logic [CNT_W-1:0]       front_age;
    swmm_pkg::swmm_sample_t front_val;
    swmm_pkg::swmm_sample_t back_val;
    logic                   front_stale;
    logic                   back_pop;
    logic                   dominated;
    logic [CNT_W-1:0]       seen_inc;
    logic                   emit;
    logic                   append_ok;
    logic                   accept;

    function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
        return (s == '0) ? PTR_W'(WINDOW_MAX - 1) : s - 1'b1;
    endfunction

    // Clamp the window length to 1..WINDOW_MAX
    assign ws_wide = 32'(cfg.window_size);
    always_comb
    begin
        if (cfg.window_size == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (ws_wide > 32'(WINDOW_MAX))
        begin
            win_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win_len = CNT_W'(ws_wide);
        end
    end

    // Unpack the front and back entries read last cycle
    assign front_pos = front_entry[CNT_W-1:0];
    assign front_val = front_entry[ENTRY_W-1 -: swmm_pkg::SAMPLE_W];
    assign back_val  = back_entry[ENTRY_W-1 -: swmm_pkg::SAMPLE_W];
    assign front_age = pos_reg - front_pos;

    assign front_stale = (count_reg != '0) && (front_age >= win_len);
    assign dominated   = cfg.select_max ? (back_val <= sample_reg) : (back_val >= sample_reg);
    assign back_pop    = (count_reg != '0) && dominated;

    assign seen_inc  = (seen_reg == CNT_W'(WINDOW_MAX)) ? seen_reg : seen_reg + 1'b1;
    assign emit      = (seen_inc >= win_len);
    assign append_ok = !emit || out_free;

    assign accept = samples.valid && samples.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swmm_pkg::ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = swmm_pkg::ST_SCAN;
                end
            end
            swmm_pkg::ST_SCAN:
            begin
                if (!front_stale && !back_pop && append_ok)
                begin
                    state_next = swmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::ST_IDLE;
            end
        endcase
    end

    // Pointer updates, append and result
    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        sample_next    = sample_reg;
        samples.ready  = 1'b0;
        wr_en          = 1'b0;
        result.valid   = 1'b0;
        result.extreme = (count_reg == '0) ? sample_reg : front_val;
        case (state_reg)
            swmm_pkg::ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    sample_next = samples.sample;
                    if (samples.new_sequence)
                    begin
                        front_next = '0;
                        back_next  = '0;
                        count_next = '0;
                        pos_next   = '0;
                        seen_next  = '0;
                    end
                end
            end
            swmm_pkg::ST_SCAN:
            begin
                if (front_stale)
                begin
                    // drop the expired front entry
                    front_next = slot_next(front_reg);
                    count_next = count_reg - 1'b1;
                end
                else if (back_pop)
                begin
                    // drop a back entry the new sample beats or ties
                    back_next  = slot_prev(back_reg);
                    count_next = count_reg - 1'b1;
                end
                else if (append_ok)
                begin
                    wr_en        = 1'b1;
                    back_next    = slot_next(back_reg);
                    count_next   = count_reg + 1'b1;
                    pos_next     = pos_reg + 1'b1;
                    seen_next    = seen_inc;
                    result.valid = emit;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmm_pkg::ST_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

    // Latch the sample under work
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    // Read ahead at the pointers of the next cycle
    assign rd_addr_back = slot_prev(back_next);

    swmm_mem #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (back_reg),
        .wr_data   ({sample_reg, pos_reg}),
        .rd_addr_a (front_next),
        .rd_addr_b (rd_addr_back),
        .rd_data_a (front_entry),
        .rd_data_b (back_entry)
    );

    `SWMM_ASSERT_SAME(a_empty_ptrs, count_reg == '0, front_reg == back_reg)
    `SWMM_ASSERT_NEXT(a_accept_scan, accept, state_reg == swmm_pkg::ST_SCAN)
    `SWMM_ASSERT_NEXT(a_append_grows, wr_en, count_reg == $past(count_reg) + 1'b1)
    `SWMM_ASSERT_SAME(a_result_append, result.valid, wr_en && out_free)
    `SWMM_ASSERT_SAME(a_seen_bound, 1'b1, seen_reg <= CNT_W'(WINDOW_MAX))

endmodule

// File: src/sliding_window_min_max.sv
// Sliding window min/max over a signed sample stream.
//
// Samples arrive on a valid/ready channel; each carries a 32-bit signed value
// and a new_sequence flag that empties the deque and restarts positions.
// Once window_size samples of the current sequence are in, every sample gives
// one result on the result channel: the minimum (select_max = 0) or maximum
// (select_max = 1) of the last window_size samples. Earlier samples give none.
// Configuration is a plain write port: register 0 is window_size (0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX), register 1 is select_max.
// A sample is taken in ST_IDLE and worked in ST_SCAN, spending a step on every
// deque entry dropped at the front or the back before the append; each entry
// is dropped at most once. The deque memory has registered read ports, and the
// sequencer steps through one pop per cycle on the front and back entries read.
// The result is registered; it turns valid after the append step, which follows
// any pops. A stalled receiver holds the result; the next sample is still
// taken, and its append waits only if it has a result to deliver.
// Reset empties the deque and sets window_size to 1 and select_max to 0.
module sliding_window_min_max #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    swmm_in_if.sink                               samples,
    swmm_out_if.source                            results,
    input  logic                                  cfg_write,
    input  logic [swmm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    swmm_pkg::swmm_cfg_t    cfg_reg;
    swmm_pkg::swmm_result_t result;
    logic                   out_valid_reg, out_valid_next;
    swmm_pkg::swmm_sample_t extreme_reg;
    logic                   out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size <= swmm_pkg::WSIZE_W'(1);
            cfg_reg.select_max  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swmm_pkg::REG_WINDOW_SIZE:
                begin
                    cfg_reg.window_size <= cfg_data[swmm_pkg::WSIZE_W-1:0];
                end
                swmm_pkg::REG_SELECT_MAX:
                begin
                    cfg_reg.select_max <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || results.ready;

    swmm_seq #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .result   (result)
    );

    // Output register: load a new result, drop a taken one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            extreme_reg <= result.extreme;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.extreme = extreme_reg;

endmodule
